// ----- rtl/spwf_pkg.sv -----
// Shared constants, codes and state type of the spectrum waterfall store.
package spwf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_ROWS   = 256;
  localparam int MAP_SIZE   = 256;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int STORE_DEPTH = MAX_ROWS * (2 ** COL_W);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int CNT_W      = $clog2(MAX_ROWS + 1);
  localparam int MAP_W      = $clog2(MAP_SIZE);

  localparam int LVL_W      = 16;
  localparam int RGB_W      = 24;
  localparam int CFG_W      = 16;

  // shift-subtract divider: at least eight quotient bits, enough for a row modulo
  localparam int DIV_STEPS  = (ROW_W > 8) ? ROW_W : 8;
  localparam int DIV_W      = LVL_W + DIV_STEPS;
  localparam int STEP_CW    = $clog2(DIV_STEPS);

  localparam logic signed [LVL_W-1:0] LVL_RESET = -16'sd1920;

  typedef enum logic [1:0] {
    CMD_BIN   = 2'd0,
    CMD_SHIFT = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CMAP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MIN   = 2'd0,
    REG_MAX   = 2'd1,
    REG_WIDTH = 2'd2,
    REG_COUNT = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NEWEST,
    ST_DIV_NEW,
    ST_BIN,
    ST_AGE,
    ST_DIV_AGE,
    ST_PHYS,
    ST_PIX_WAIT,
    ST_MAP,
    ST_DIV_MAP,
    ST_CMAP_RD,
    ST_CMAP_WAIT,
    ST_SHIFT,
    ST_ROW,
    ST_MV_RD,
    ST_MV_WR,
    ST_FILL
  } state_t;

endpackage

// ----- rtl/spwf_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module spwf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/spectrum_waterfall_store_core.sv -----
// Spectrum waterfall store: ring of spectrum rows, sideways shift, colormapped pixel reads.
//
// Holds a ring of spectrum rows (signed levels in 1/16 dB) in one block RAM and a
// 256-entry RGB colormap in a second RAM. One transaction at a time is worked by a
// small sequencer around a single shift-subtract divider; in_stall stays high until
// the transaction is finished and any pixel result has been taken. After reset a
// clearing pass writes LVL_RESET into all MAX_ROWS x 2**ceil(log2(MAX_WIDTH)) store
// words and loads the grayscale ramp into the colormap; configuration writes are
// taken during that pass, input transactions are not. A row bin writes its level into
// the next column of its row; a last bin fills any columns left unwritten with
// min_level. A pixel read maps the level to a colormap index with the eight-step
// divide (skipped when max_level <= min_level) and makes two registered RAM reads; a
// colormap write is made on acceptance. A modulo of the newest-row pointer or the
// age (only needed after row_count has been lowered) also runs the divider. A
// horizontal shift walks every row in use through the store read and write ports,
// moving the kept columns and filling the open end with min_level, or only fills a
// row that the shift clears. Pixel results leave through an output register that
// holds while out_stall is high.
module spectrum_waterfall_store_core
  import spwf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_cmd,
  input  logic signed [LVL_W-1:0] in_level,
  input  logic                    in_last_bin,
  input  logic signed [11:0]      in_shift_bins,
  input  logic [7:0]              in_row_age,
  input  logic [9:0]              in_column,
  input  logic [7:0]              in_color_index,
  input  logic [RGB_W-1:0]        in_color_rgb,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue
);

  // ---------------------------------------------------------------- registers
  state_t state_r, state_nxt;

  logic signed [LVL_W-1:0] min_r, max_r;
  logic [10:0]             width_r;
  logic [8:0]              count_r;

  logic [ROW_W-1:0] newest_r, newest_nxt;
  logic [WID_W-1:0] wcol_r, wcol_nxt;
  logic             open_r, open_nxt;

  // captured transaction
  cmd_t                    cmd_r;
  logic signed [LVL_W-1:0] lvl_in_r;
  logic                    last_r;
  logic signed [11:0]      shift_r;
  logic [7:0]              age_r;
  logic [9:0]              col_r;

  logic [ROW_W-1:0] nm_r, nm_nxt;     // newest row modulo count
  logic [ROW_W-1:0] am_r, am_nxt;     // age modulo count
  logic             col_ok_r, col_ok_nxt;
  logic signed [LVL_W-1:0] pix_r, pix_nxt;
  logic [MAP_W-1:0] idx_r, idx_nxt;

  // shared divider
  logic [DIV_W-1:0]     div_rem_r, div_rem_nxt;
  logic [DIV_W-1:0]     div_dsh_r, div_dsh_nxt;
  logic [DIV_STEPS-1:0] div_quo_r, div_quo_nxt;
  logic [STEP_CW-1:0]   div_cnt_r, div_cnt_nxt;

  logic [ADDR_W-1:0] clr_r, clr_nxt;

  // row walk for fills and shifts
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WID_W-1:0] fcol_r, fcol_nxt;
  logic [WID_W-1:0] fend_r, fend_nxt;
  logic             shmode_r, shmode_nxt;
  logic [11:0]      mag_r, mag_nxt;
  logic [WID_W-1:0] dst_r, dst_nxt;
  logic [WID_W-1:0] left_r, left_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_red_r, out_green_r, out_blue_r;
  logic [7:0]       out_red_nxt, out_green_nxt, out_blue_nxt;

  // ---------------------------------------------------------------- memories
  logic               st_we;
  logic [ADDR_W-1:0]  st_waddr, st_raddr;
  logic [LVL_W-1:0]   st_wdata, st_rdata;
  logic               cm_we;
  logic [MAP_W-1:0]   cm_waddr;
  logic [RGB_W-1:0]   cm_wdata, cm_rdata;

  spwf_ram #(.WIDTH(LVL_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  spwf_ram #(.WIDTH(RGB_W), .DEPTH(MAP_SIZE)) u_cmap (
    .clk   (clk),
    .we    (cm_we),
    .waddr (cm_waddr),
    .wdata (cm_wdata),
    .raddr (idx_r),
    .rdata (cm_rdata)
  );

  // ---------------------------------------------------------------- common logic
  logic             accept;
  logic [WID_W-1:0] w_used;
  logic [CNT_W-1:0] n_used;

  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign accept   = in_valid && !in_stall;

  // clamp the width and count registers into the range the store can hold
  always_comb begin
    if (width_r == '0) begin
      w_used = WID_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_used = WID_W'(MAX_WIDTH);
    end else begin
      w_used = WID_W'(width_r);
    end
    if (count_r == '0) begin
      n_used = CNT_W'(1);
    end else if (32'(count_r) > MAX_ROWS) begin
      n_used = CNT_W'(MAX_ROWS);
    end else begin
      n_used = CNT_W'(count_r);
    end
  end

  // one restoring divide step
  logic [DIV_W:0]       div_diff;
  logic                 div_ge;
  logic [DIV_W-1:0]     div_rem_step;
  logic [DIV_STEPS-1:0] div_quo_step;
  logic                 div_last;

  assign div_diff     = {1'b0, div_rem_r} - {1'b0, div_dsh_r};
  assign div_ge       = !div_diff[DIV_W];
  assign div_rem_step = div_ge ? div_diff[DIV_W-1:0] : div_rem_r;
  assign div_quo_step = {div_quo_r[DIV_STEPS-2:0], div_ge};
  assign div_last     = (div_cnt_r == '0);

  // row bin: target row and column after this bin
  logic [CNT_W-1:0] nm_inc;
  logic [ROW_W-1:0] bin_row;
  logic [WID_W-1:0] bin_wc;
  logic             bin_wr;
  logic [WID_W-1:0] bin_wc1;

  assign nm_inc  = CNT_W'(nm_r) + CNT_W'(1);
  assign bin_row = open_r ? nm_r : ((nm_inc == n_used) ? '0 : nm_inc[ROW_W-1:0]);
  assign bin_wc  = open_r ? wcol_r : '0;
  assign bin_wr  = bin_wc < w_used;
  assign bin_wc1 = bin_wr ? bin_wc + WID_W'(1) : bin_wc;

  // pixel row from the age
  logic [CNT_W-1:0] phys;
  assign phys = (nm_r >= am_r) ? CNT_W'(nm_r) - CNT_W'(am_r)
                               : CNT_W'(nm_r) + n_used - CNT_W'(am_r);

  // level to colormap numerator and divisor
  logic                    map_empty;
  logic signed [LVL_W-1:0] pix_clamp;
  logic signed [LVL_W:0]   map_diff;
  logic signed [LVL_W:0]   map_span;
  logic [DIV_W-1:0]        map_num;

  assign map_empty = (max_r <= min_r);
  assign pix_clamp = (pix_r < min_r) ? min_r : ((pix_r > max_r) ? max_r : pix_r);
  assign map_diff  = LVL_W'(0) + (17'(pix_clamp) - 17'(min_r));
  assign map_span  = 17'(max_r) - 17'(min_r);
  assign map_num   = (DIV_W'(map_diff[LVL_W-1:0]) << 8) - DIV_W'(map_diff[LVL_W-1:0]);

  // shift walk
  logic             sh_pos;
  logic             sh_clear;
  logic [WID_W-1:0] mag_w;
  logic [WID_W-1:0] mv_src;
  logic             fill_done;
  logic             row_more;

  assign sh_pos    = !shift_r[11];
  assign sh_clear  = 32'(mag_r) >= 32'(w_used);
  assign mag_w     = mag_r[WID_W-1:0];
  assign mv_src    = sh_pos ? dst_r - mag_w : dst_r + mag_w;
  assign fill_done = (fcol_r + WID_W'(1)) >= fend_r;
  assign row_more  = shmode_r && ((CNT_W'(row_r) + CNT_W'(1)) < n_used);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_cmd))
            CMD_BIN, CMD_READ: state_nxt = ST_NEWEST;
            CMD_SHIFT:         state_nxt = ST_SHIFT;
            default:           state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_NEWEST: begin
        if (CNT_W'(newest_r) < n_used) begin
          state_nxt = (cmd_r == CMD_BIN) ? ST_BIN : ST_AGE;
        end else begin
          state_nxt = ST_DIV_NEW;
        end
      end
      ST_DIV_NEW: begin
        if (div_last) begin
          state_nxt = (cmd_r == CMD_BIN) ? ST_BIN : ST_AGE;
        end
      end
      ST_BIN: begin
        state_nxt = (last_r && (bin_wc1 < w_used)) ? ST_FILL : ST_IDLE;
      end
      ST_AGE: begin
        state_nxt = (CNT_W'(age_r) < n_used) ? ST_PHYS : ST_DIV_AGE;
      end
      ST_DIV_AGE: begin
        if (div_last) begin
          state_nxt = ST_PHYS;
        end
      end
      ST_PHYS:      state_nxt = ST_PIX_WAIT;
      ST_PIX_WAIT:  state_nxt = ST_MAP;
      ST_MAP:       state_nxt = map_empty ? ST_CMAP_RD : ST_DIV_MAP;
      ST_DIV_MAP: begin
        if (div_last) begin
          state_nxt = ST_CMAP_RD;
        end
      end
      ST_CMAP_RD:   state_nxt = ST_CMAP_WAIT;
      ST_CMAP_WAIT: state_nxt = ST_IDLE;
      ST_SHIFT:     state_nxt = (shift_r == '0) ? ST_IDLE : ST_ROW;
      ST_ROW:       state_nxt = sh_clear ? ST_FILL : ST_MV_RD;
      ST_MV_RD:     state_nxt = ST_MV_WR;
      ST_MV_WR:     state_nxt = (left_r == '0) ? ST_FILL : ST_MV_RD;
      ST_FILL: begin
        if (fill_done) begin
          state_nxt = row_more ? ST_ROW : ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath and memory controls
  always_comb begin
    newest_nxt    = newest_r;
    wcol_nxt      = wcol_r;
    open_nxt      = open_r;
    nm_nxt        = nm_r;
    am_nxt        = am_r;
    col_ok_nxt    = col_ok_r;
    pix_nxt       = pix_r;
    idx_nxt       = idx_r;
    div_rem_nxt   = div_rem_r;
    div_dsh_nxt   = div_dsh_r;
    div_quo_nxt   = div_quo_r;
    div_cnt_nxt   = div_cnt_r;
    clr_nxt       = clr_r;
    row_nxt       = row_r;
    fcol_nxt      = fcol_r;
    fend_nxt      = fend_r;
    shmode_nxt    = shmode_r;
    mag_nxt       = mag_r;
    dst_nxt       = dst_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_red_nxt   = out_red_r;
    out_green_nxt = out_green_r;
    out_blue_nxt  = out_blue_r;

    st_we    = 1'b0;
    st_waddr = {row_r, fcol_r[COL_W-1:0]};
    st_wdata = min_r;
    st_raddr = {row_r, mv_src[COL_W-1:0]};
    cm_we    = 1'b0;
    cm_waddr = in_color_index[MAP_W-1:0];
    cm_wdata = in_color_rgb;

    unique case (state_r)
      ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        st_wdata = LVL_RESET;
        if (32'(clr_r) < MAP_SIZE) begin
          cm_we    = 1'b1;
          cm_waddr = clr_r[MAP_W-1:0];
          cm_wdata = {3{8'(clr_r[MAP_W-1:0])}};
        end
        clr_nxt = clr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (accept && (cmd_t'(in_cmd) == CMD_CMAP)) begin
          cm_we = 1'b1;
        end
      end
      ST_NEWEST: begin
        nm_nxt      = newest_r;
        div_rem_nxt = DIV_W'(newest_r);
        div_dsh_nxt = DIV_W'(n_used) << (DIV_STEPS - 1);
        div_cnt_nxt = STEP_CW'(DIV_STEPS - 1);
      end
      ST_DIV_NEW, ST_DIV_AGE, ST_DIV_MAP: begin
        div_rem_nxt = div_rem_step;
        div_quo_nxt = div_quo_step;
        div_dsh_nxt = div_dsh_r >> 1;
        div_cnt_nxt = div_cnt_r - STEP_CW'(1);
        if (div_last) begin
          if (state_r == ST_DIV_NEW) begin
            nm_nxt = div_rem_step[ROW_W-1:0];
          end else if (state_r == ST_DIV_AGE) begin
            am_nxt = div_rem_step[ROW_W-1:0];
          end else begin
            idx_nxt = div_quo_step[MAP_W-1:0];
          end
        end
      end
      ST_BIN: begin
        if (!open_r) begin
          newest_nxt = bin_row;
        end
        open_nxt = !last_r;
        wcol_nxt = bin_wc1;
        if (bin_wr) begin
          st_we    = 1'b1;
          st_waddr = {bin_row, bin_wc[COL_W-1:0]};
          st_wdata = lvl_in_r;
        end
        // close the row: fill the columns that were never written
        row_nxt    = bin_row;
        fcol_nxt   = bin_wc1;
        fend_nxt   = w_used;
        shmode_nxt = 1'b0;
      end
      ST_AGE: begin
        am_nxt      = age_r[ROW_W-1:0];
        div_rem_nxt = DIV_W'(age_r);
        div_dsh_nxt = DIV_W'(n_used) << (DIV_STEPS - 1);
        div_cnt_nxt = STEP_CW'(DIV_STEPS - 1);
      end
      ST_PHYS: begin
        st_raddr   = {phys[ROW_W-1:0], COL_W'(col_r)};
        col_ok_nxt = 32'(col_r) < 32'(w_used);
      end
      ST_PIX_WAIT: begin
        pix_nxt = col_ok_r ? $signed(st_rdata) : min_r;
      end
      ST_MAP: begin
        idx_nxt     = '0;
        div_rem_nxt = map_num;
        div_dsh_nxt = DIV_W'(map_span[LVL_W-1:0]) << (DIV_STEPS - 1);
        div_cnt_nxt = STEP_CW'(DIV_STEPS - 1);
      end
      ST_CMAP_RD: begin
      end
      ST_CMAP_WAIT: begin
        out_valid_nxt = 1'b1;
        out_red_nxt   = cm_rdata[7:0];
        out_green_nxt = cm_rdata[15:8];
        out_blue_nxt  = cm_rdata[23:16];
      end
      ST_SHIFT: begin
        mag_nxt = shift_r[11] ? 12'(-shift_r) : 12'(shift_r);
        row_nxt = '0;
      end
      ST_ROW: begin
        shmode_nxt = 1'b1;
        if (sh_clear) begin
          fcol_nxt = '0;
          fend_nxt = w_used;
        end else begin
          dst_nxt  = sh_pos ? w_used - WID_W'(1) : '0;
          left_nxt = w_used - mag_w - WID_W'(1);
        end
      end
      ST_MV_RD: begin
        st_raddr = {row_r, mv_src[COL_W-1:0]};
      end
      ST_MV_WR: begin
        st_we    = 1'b1;
        st_waddr = {row_r, dst_r[COL_W-1:0]};
        st_wdata = st_rdata;
        dst_nxt  = sh_pos ? dst_r - WID_W'(1) : dst_r + WID_W'(1);
        left_nxt = left_r - WID_W'(1);
        // open end of the row takes min_level
        fcol_nxt = sh_pos ? '0 : w_used - mag_w;
        fend_nxt = sh_pos ? mag_w : w_used;
      end
      ST_FILL: begin
        st_we    = 1'b1;
        fcol_nxt = fcol_r + WID_W'(1);
        if (fill_done && row_more) begin
          row_nxt = row_r + ROW_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- register update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      min_r       <= LVL_RESET;
      max_r       <= '0;
      width_r     <= 11'(MAX_WIDTH);
      count_r     <= 9'(MAX_ROWS);
      newest_r    <= '0;
      wcol_r      <= '0;
      open_r      <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      wcol_r      <= wcol_nxt;
      open_r      <= open_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MIN:   min_r   <= $signed(cfg_data);
          REG_MAX:   max_r   <= $signed(cfg_data);
          REG_WIDTH: width_r <= cfg_data[10:0];
          REG_COUNT: count_r <= cfg_data[8:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= cmd_t'(in_cmd);
      lvl_in_r <= in_level;
      last_r   <= in_last_bin;
      shift_r  <= in_shift_bins;
      age_r    <= in_row_age;
      col_r    <= in_column;
    end
    nm_r        <= nm_nxt;
    am_r        <= am_nxt;
    col_ok_r    <= col_ok_nxt;
    pix_r       <= pix_nxt;
    idx_r       <= idx_nxt;
    div_rem_r   <= div_rem_nxt;
    div_dsh_r   <= div_dsh_nxt;
    div_quo_r   <= div_quo_nxt;
    div_cnt_r   <= div_cnt_nxt;
    row_r       <= row_nxt;
    fcol_r      <= fcol_nxt;
    fend_r      <= fend_nxt;
    shmode_r    <= shmode_nxt;
    mag_r       <= mag_nxt;
    dst_r       <= dst_nxt;
    left_r      <= left_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // ---------------------------------------------------------------- assertions
  a_result_from_cmap: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_CMAP_WAIT)
    else $error("pixel result raised outside the colormap read");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("transaction accepted during the clearing pass");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (fcol_r < fend_r))
    else $error("fill column beyond its end");

  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV_NEW || state_r == ST_DIV_AGE || state_r == ST_DIV_MAP)
     && !div_last) |=> (state_r == $past(state_r)))
    else $error("divider left before its last step");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for spectrum_waterfall_store_core.
module tb;
  import spwf_pkg::*;

  typedef logic signed [LVL_W-1:0] lvl_t;
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_cmd;
  lvl_t              in_level;
  logic              in_last_bin;
  logic signed [11:0] in_shift_bins;
  logic [7:0]        in_row_age;
  logic [9:0]        in_column;
  logic [7:0]        in_color_index;
  logic [RGB_W-1:0]  in_color_rgb;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_red;
  logic [7:0]        out_green;
  logic [7:0]        out_blue;

  spectrum_waterfall_store_core u_dut (.*);

  // Shadow copy of the block: registers, row ring, stream position, colormap.
  lvl_t              min_lvl;
  lvl_t              max_lvl;
  logic [10:0]       width_reg;
  logic [8:0]        count_reg;
  lvl_t              ring [0:MAX_ROWS*MAX_WIDTH-1];
  int unsigned       newest;
  int unsigned       wr_col;
  bit                row_busy;
  logic [RGB_W-1:0]  cmap [0:MAP_SIZE-1];

  pixel_t            pixel_q[$];
  int                errors;
  int                items_sent;
  int                hold_req;

  // Clock: period 12.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 20000000);
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned width_used();
    if (width_reg == 0) return 1;
    return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
  endfunction

  function automatic int unsigned count_used();
    if (count_reg == 0) return 1;
    return (count_reg > MAX_ROWS) ? MAX_ROWS : count_reg;
  endfunction

  function automatic void fill_row(int unsigned r, int unsigned from, int unsigned to);
    for (int unsigned i = from; i < to && i < MAX_WIDTH; i++) ring[r*MAX_WIDTH + i] = min_lvl;
  endfunction

  function automatic logic [7:0] color_slot(lvl_t lv);
    longint lo, hi, v;
    lo = min_lvl;
    hi = max_lvl;
    v  = lv;
    if (hi <= lo) return 8'd0;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    v = (255 * (v - lo)) / (hi - lo);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Apply one accepted transaction to the shadow state; queue any pixel it returns.
  function automatic void apply_transaction(cmd_t c, lvl_t lv, bit last, logic signed [11:0] sh,
                                            logic [7:0] age, logic [9:0] col,
                                            logic [7:0] ci, logic [RGB_W-1:0] rgb);
    int unsigned w, n, mag, a, phys, base;
    lvl_t        pix;
    logic [RGB_W-1:0] entry;
    pixel_t      px;
    w = width_used();
    n = count_used();
    case (c)
      CMD_BIN: begin
        if (!row_busy) begin
          newest   = (newest % n + 1) % n;
          wr_col   = 0;
          row_busy = 1'b1;
        end
        base = newest % n;
        if (wr_col < w) begin
          ring[base*MAX_WIDTH + wr_col] = lv;
          wr_col++;
        end
        if (last) begin
          fill_row(base, (wr_col < w) ? wr_col : w, w);
          row_busy = 1'b0;
        end
      end
      CMD_SHIFT: begin
        mag = (sh < 0) ? -sh : sh;
        if (sh != 0) begin
          for (int unsigned r = 0; r < n; r++) begin
            if (mag >= w) fill_row(r, 0, w);
            else if (sh > 0) begin
              for (int unsigned i = w; i-- > mag;)
                ring[r*MAX_WIDTH + i] = ring[r*MAX_WIDTH + i - mag];
              fill_row(r, 0, mag);
            end else begin
              for (int unsigned i = 0; i + mag < w; i++)
                ring[r*MAX_WIDTH + i] = ring[r*MAX_WIDTH + i + mag];
              fill_row(r, w - mag, w);
            end
          end
        end
      end
      CMD_READ: begin
        a     = age % n;
        phys  = (newest % n + n - a) % n;
        pix   = (col < w) ? ring[phys*MAX_WIDTH + col] : min_lvl;
        entry = cmap[color_slot(pix)];
        px    = '{red: entry[7:0], green: entry[15:8], blue: entry[23:16]};
        pixel_q.insert(pixel_q.size(), px);
      end
      default: cmap[ci] = rgb;
    endcase
  endfunction

  // Send one transaction; hold the payload until it is taken.
  task automatic send_item(cmd_t c, lvl_t lv, bit last, logic signed [11:0] sh,
                           logic [7:0] age, logic [9:0] col,
                           logic [7:0] ci, logic [RGB_W-1:0] rgb);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_cmd         <= c;
    in_level       <= lv;
    in_last_bin    <= last;
    in_shift_bins  <= sh;
    in_row_age     <= age;
    in_column      <= col;
    in_color_index <= ci;
    in_color_rgb   <= rgb;
    do @(posedge clk); while (in_stall);
    apply_transaction(c, lv, last, sh, age, col, ci, rgb);
    items_sent++;
  endtask

  // Unused fields carry random bits.
  task automatic send_bin(lvl_t lv, bit last);
    send_item(CMD_BIN, lv, last, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_shift(logic signed [11:0] sh);
    send_item(CMD_SHIFT, $urandom, $urandom, sh, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_read(logic [7:0] age, logic [9:0] col);
    send_item(CMD_READ, $urandom, $urandom, $urandom, age, col, $urandom, $urandom);
  endtask

  task automatic send_cmap(logic [7:0] ci, logic [RGB_W-1:0] rgb);
    send_item(CMD_CMAP, $urandom, $urandom, $urandom, $urandom, $urandom, ci, rgb);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_MIN:   min_lvl   = val;
      REG_MAX:   max_lvl   = val;
      REG_WIDTH: width_reg = val[10:0];
      default:   count_reg = val[8:0];
    endcase
  endtask

  // Drain all pixels, then give the block time to finish a trailing shift or row fill.
  task automatic wait_quiet();
    idle_cycles(1);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (count_used() * (2 * width_used() + 2) + width_used() + 64) @(posedge clk);
  endtask

  task automatic set_view(lvl_t lo, lvl_t hi, logic [10:0] w, logic [8:0] n);
    wait_quiet();
    write_reg(REG_MIN, lo);
    write_reg(REG_MAX, hi);
    write_reg(REG_WIDTH, w);
    write_reg(REG_COUNT, n);
  endtask

  // Defaults: the first send also waits out the clearing pass after reset.
  task automatic test_defaults();
    send_read(8'd0, 10'd0);
    send_read(8'd255, 10'd1023);
    send_bin(16'sh7fff, 1'b0);
    send_bin(-16'sd32768, 1'b0);
    send_bin(16'sd0, 1'b0);
    send_bin(-16'sd960, 1'b1);         // short row: the rest fills with min_level
    for (int i = 0; i < 5; i++) send_read(8'd0, i);
    send_read(8'd0, 10'd1023);
    send_cmap(8'd255, 24'hffffff);
    send_cmap(8'd0, 24'h123456);
    send_read(8'd0, 10'd0);
    send_read(8'd0, 10'd2);
    send_read(8'd1, 10'd0);            // previous row, never streamed
  endtask

  // Out-of-range width and count, inverted and flat ranges, shift extremes.
  task automatic test_limits();
    set_view(16'sh7fff, -16'sd32768, 11'd0, 9'd0);
    send_bin(16'sd5, 1'b0);
    send_bin(16'sd6, 1'b1);            // bin beyond the width still closes the row
    send_read(8'd200, 10'd0);
    send_read(8'd0, 10'd1);
    set_view(-16'sd32768, 16'sh7fff, 11'd4, 9'd3);
    for (int i = 0; i < 4; i++) send_bin(i == 0 ? -16'sd32768 : 16'sh7fff - i, i == 3);
    send_shift(12'sd0);
    send_shift(12'sd1);
    send_read(8'd0, 10'd0);
    send_read(8'd0, 10'd1);
    send_shift(-12'sd2);
    send_read(8'd0, 10'd1);
    send_read(8'd3, 10'd3);            // age wraps around the ring
    send_shift(12'sd1024);
    send_read(8'd0, 10'd1);
    set_view(16'sd100, 16'sd100, 11'd2047, 9'd2);
    send_bin(16'sd200, 1'b1);
    send_shift(-12'sd1024);
    send_shift(-12'sd1023);
    send_read(8'd0, 10'd0);
    set_view(-16'sd1920, 16'sd0, 11'd16, 9'd511);
    send_read(8'd1, 10'd3);
  endtask

  // Hold the result side off for a long stretch while reads keep arriving.
  task automatic test_backpressure();
    set_view(-16'sd512, 16'sd512, 11'd8, 9'd4);
    hold_req = 400;
    for (int i = 0; i < 8; i++) send_read($urandom, $urandom_range(0, 9));
    idle_cycles(2);
  endtask

  // Random phases: mostly well-formed rows and reads, with shifts, colormap writes
  // and noise mixed in; each phase runs under a fresh register setting.
  task automatic test_random();
    int unsigned burst, len, w, pick, phase_items;
    lvl_t lo, hi;
    burst = 0;
    while (items_sent < 1900) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        lo = $urandom;
        hi = $urandom;
      end else begin
        lo = -$signed($urandom_range(0, 3000));
        hi = (pick == 1) ? lo : lo + $signed($urandom_range(1, 2500));
      end
      set_view(lo, hi, (pick == 2) ? 11'($urandom_range(0, 2047)) : 11'($urandom_range(1, 40)),
               (pick == 3) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(1, 10)));
      w = width_used();
      phase_items = 0;
      while (phase_items < 150 && items_sent < 1900) begin
        if (burst == 0) begin
          idle_cycles($urandom_range(1, 8));
          burst = $urandom_range(1, 40);
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          len = (w > 64) ? $urandom_range(1, 6) : $urandom_range(1, w + 3);
          for (int unsigned j = 0; j < len; j++)
            send_bin(($urandom_range(0, 3) == 0) ? lvl_t'($urandom)
                     : lo + $signed($urandom_range(0, 2600)),
                     (j == len - 1) && ($urandom_range(0, 9) != 0));
          phase_items += len;
        end else if (pick < 82) begin
          send_read($urandom, $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, w));
          phase_items++;
        end else if (pick < 88) begin
          send_cmap($urandom, $urandom);
          phase_items++;
        end else if (pick < 94) begin
          if (count_used() * w <= 4096) begin
            send_shift($urandom_range(0, 4) == 0 ? $signed($urandom_range(0, 2048)) - 1024
                       : $signed($urandom_range(0, 2 * w + 2)) - w - 1);
            phase_items++;
          end
        end else begin
          if (count_used() * w <= 4096 || $urandom_range(0, 1) == 0)
            send_item(cmd_t'($urandom_range(0, 2) == 1 ? CMD_BIN : CMD_READ), $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          phase_items++;
        end
        burst--;
      end
    end
  endtask

  // Receiver stall pattern: segments of no stall, random stall, or alternating.
  initial begin
    int hold_left, seg, mode;
    bit flip;
    out_stall = 1'b1;
    hold_left = 0;
    seg = 0;
    flip = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (seg == 0) begin
          mode = $urandom_range(0, 2);
          seg  = $urandom_range(16, 96);
        end
        seg--;
        flip = ~flip;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= flip;
        endcase
      end
    end
  end

  // Compare each taken pixel with the oldest prediction.
  always @(posedge clk) begin
    pixel_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{red: out_red, green: out_green, blue: out_blue};
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (got.red !== want.red) begin
          $display("%0t: red expected %h actual %h", $time, want.red, got.red);
          errors++;
        end
        if (got.green !== want.green) begin
          $display("%0t: green expected %h actual %h", $time, want.green, got.green);
          errors++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MIN;
    cfg_data = '0;
    in_valid = 1'b0;
    in_cmd = CMD_BIN;
    in_level = '0;
    in_last_bin = 1'b0;
    in_shift_bins = '0;
    in_row_age = '0;
    in_column = '0;
    in_color_index = '0;
    in_color_rgb = '0;
    errors = 0;
    items_sent = 0;
    hold_req = 0;
    min_lvl = LVL_RESET;
    max_lvl = '0;
    width_reg = 11'd1024;
    count_reg = 9'd256;
    newest = 0;
    wr_col = 0;
    row_busy = 1'b0;
    for (int i = 0; i < MAX_ROWS * MAX_WIDTH; i++) ring[i] = LVL_RESET;
    for (int i = 0; i < MAP_SIZE; i++) cmap[i] = i * 24'h010101;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_defaults();
    test_limits();
    test_backpressure();
    test_random();
    wait_quiet();

    if (errors == 0 && pixel_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
